// File: hw/rtl/pbd_pkg.sv
// shared types and constants for the 6-bit packbits decoder
`default_nettype none

package pbd_pkg;

  localparam int SYM_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int STORE_DEPTH = 32;
  localparam int ACC_W       = BYTE_W + SYM_W - 1;  // up to five leftover bits plus a byte
  localparam int LEFT_W      = SYM_W - 1;
  localparam int CNT_W       = 4;

  localparam logic [SYM_W-1:0] SYM_MASK = 6'h3F;
  localparam logic [SYM_W-1:0] SIGN_BIT = 6'h20;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              last_byte;
  } in_t;

  typedef struct packed {
    logic [SYM_W-1:0] out_symbol;
    logic             item_last;
  } out_t;

endpackage

`default_nettype wire

// File: hw/rtl/pbd_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module pbd_ram #(
  parameter int DATA_W = 6,
  parameter int DEPTH  = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/packbits_decoder_6bit.sv
// top level of the streaming packbits decoder over 6-bit symbols
`default_nettype none

// Takes one compressed byte per input transfer and cuts it, together with up to
// five bits left over from earlier bytes, into 6-bit symbols, most significant
// bit first. A header of 0..31 opens a literal run of header+1 symbols that is
// held in a 32-entry store and sent only once complete; a header of -32..-1
// repeats the following symbol 2..33 times. item_last marks the final symbol a
// byte produces; a byte flagged last_byte drops any unfinished run and trailing
// bits. A byte is taken while idle; the shared shifter then cuts one or two
// symbols from it in turn, and then the byte is closed out. A run burst first
// prefetches from the store and then sends one symbol per cycle while
// out_stall is low. in_stall stays high from the transfer until the byte is
// fully done; a result may still sit in the output register when the next
// byte is taken.
module packbits_decoder_6bit
  import pbd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_stall,
  input  wire in_t  in_data,
  output      logic out_valid,
  input  wire logic out_stall,
  output      out_t out_data
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a byte
  localparam logic [1:0] ST_CUT  = 2'd1;  // cut and decode one symbol per cycle
  localparam logic [1:0] ST_PREF = 2'd2;  // prefetch first literal from the store
  localparam logic [1:0] ST_EMIT = 2'd3;  // send one result per cycle while the output register is free

  // decode phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LITERAL = 2'd1;
  localparam logic [1:0] PH_REPEAT  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              last_r, last_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic [2:0]        left_cnt_r, left_cnt_nxt;
  logic [SYM_W-1:0]  pending_r, pending_nxt;
  logic [SYM_W-1:0]  fill_r, fill_nxt;
  logic [SYM_W-1:0]  emit_len_r, emit_len_nxt;
  logic [SYM_W-1:0]  emit_idx_r, emit_idx_nxt;
  logic              emit_lit_r, emit_lit_nxt;
  logic [SYM_W-1:0]  rep_sym_r, rep_sym_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic              in_xfer;
  logic              can_load;
  logic              emit_done;
  logic [2:0]        shamt;
  logic [SYM_W-1:0]  sym;
  logic [SYM_W-1:0]  fill_inc;
  logic [SYM_W-1:0]  idx_inc;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SYM_W-1:0]  ram_rdata;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // output register is free when empty or being taken this cycle
  assign can_load = !out_valid_r || !out_stall;

  // shared shifter: pick the six bits just below the valid count
  assign shamt = 3'(cnt_r - CNT_W'(SYM_W));
  assign sym   = SYM_W'(acc_r >> shamt) & SYM_MASK;

  assign fill_inc  = fill_r + SYM_W'(1);
  assign idx_inc   = emit_idx_r + SYM_W'(1);
  assign emit_done = (emit_idx_r == emit_len_r - SYM_W'(1));

  // a symbol that emits leaves the decoder expecting a header, so the second
  // symbol of the byte never emits and every burst ends the byte's results
  assign ram_we    = (state_r == ST_CUT) && (cnt_r >= CNT_W'(SYM_W)) &&
                     (phase_r == PH_LITERAL);
  assign ram_re    = (state_r == ST_PREF) || ((state_r == ST_EMIT) && can_load);
  assign ram_raddr = (state_r == ST_PREF) ? '0 : idx_inc[ADDR_W-1:0];

  pbd_ram #(
    .DATA_W (SYM_W),
    .DEPTH  (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data (sym),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    left_nxt      = left_r;
    left_cnt_nxt  = left_cnt_r;
    pending_nxt   = pending_r;
    fill_nxt      = fill_r;
    emit_len_nxt  = emit_len_r;
    emit_idx_nxt  = emit_idx_r;
    emit_lit_nxt  = emit_lit_r;
    rep_sym_nxt   = rep_sym_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // output register drains independently of the sequencer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          // bits above the valid count are never selected, so no masking
          acc_nxt   = {left_r, in_data.in_byte};
          cnt_nxt   = CNT_W'(left_cnt_r) + CNT_W'(BYTE_W);
          last_nxt  = in_data.last_byte;
          state_nxt = ST_CUT;
        end
      end

      ST_CUT: begin
        if (cnt_r >= CNT_W'(SYM_W)) begin
          cnt_nxt = cnt_r - CNT_W'(SYM_W);
          case (phase_r)
            PH_LITERAL: begin
              fill_nxt = fill_inc;
              if (fill_inc >= pending_r) begin
                emit_len_nxt = pending_r;
                emit_lit_nxt = 1'b1;
                emit_idx_nxt = '0;
                phase_nxt    = PH_HEADER;
                pending_nxt  = '0;
                fill_nxt     = '0;
                state_nxt    = ST_PREF;
              end
            end
            PH_REPEAT: begin
              emit_len_nxt = pending_r;
              emit_lit_nxt = 1'b0;
              emit_idx_nxt = '0;
              rep_sym_nxt  = sym;
              phase_nxt    = PH_HEADER;
              pending_nxt  = '0;
              state_nxt    = ST_PREF;
            end
            default: begin
              // header; the unused phase code also lands here
              if ((sym & SIGN_BIT) != '0) begin
                // count = 1 - (sym - 64), range 2..33
                pending_nxt = SYM_W'(7'd65 - {1'b0, sym});
                phase_nxt   = PH_REPEAT;
              end else begin
                pending_nxt = sym + SYM_W'(1);
                fill_nxt    = '0;
                phase_nxt   = PH_LITERAL;
              end
            end
          endcase
        end else begin
          // close out the byte
          left_nxt     = acc_r[LEFT_W-1:0];
          left_cnt_nxt = cnt_r[2:0];
          if (last_r) begin
            left_nxt     = '0;
            left_cnt_nxt = '0;
            phase_nxt    = PH_HEADER;
            pending_nxt  = '0;
            fill_nxt     = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_PREF: begin
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (can_load) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_symbol = emit_lit_r ? ram_rdata : rep_sym_r;
          out_data_nxt.item_last  = emit_done;
          emit_idx_nxt            = idx_inc;
          if (emit_done) begin
            state_nxt = ST_CUT;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_HEADER;
      left_r      <= '0;
      left_cnt_r  <= '0;
      pending_r   <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      left_r      <= left_nxt;
      left_cnt_r  <= left_cnt_nxt;
      pending_r   <= pending_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers, no reset needed
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    last_r     <= last_nxt;
    emit_len_r <= emit_len_nxt;
    emit_idx_r <= emit_idx_nxt;
    emit_lit_r <= emit_lit_nxt;
    rep_sym_r  <= rep_sym_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/pbd_checker.sv
// port-level checker for the 6-bit packbits decoder, bound to the top level
`default_nettype none

module pbd_checker
  import pbd_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // no result right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a taken byte keeps the block busy for at least the next cycle
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new byte taken right after a transfer");

  // more results of the same byte follow, so the block is still busy
  a_busy_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.item_last |=> in_stall)
    else $error("input ready in the middle of a burst");

endmodule

bind packbits_decoder_6bit pbd_checker u_pbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: bench/tb_packbits_decoder_6bit.sv
// self-checking testbench for packbits_decoder_6bit: random handshakes, predicted symbol stream
module tb_packbits_decoder_6bit;
  import pbd_pkg::*;

  localparam int RANDOM_BYTES = 360;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = 64;
  localparam int MAX_SHOWN    = 10;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } phase_e;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  packbits_decoder_6bit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // stimulus and expected results
  in_t        byte_q[$];
  logic [5:0] sym_buf[$];
  out_t       symbols_due[$];
  logic [5:0] burst_syms[$];

  // decoder state mirror
  logic [4:0] left_bits = '0;
  logic [2:0] left_cnt  = '0;
  phase_e     phase     = PH_HEADER;
  logic [5:0] run_len   = '0;
  logic [5:0] fill_cnt  = '0;
  logic [5:0] lit_store [32];

  // bookkeeping
  int cycle_count     = 0;
  int bytes_taken     = 0;
  int n_issued        = 0;
  int results_checked = 0;
  int results_seen    = 0;
  int err_count       = 0;
  int total_bytes     = 0;
  int directed_bytes  = 0;
  int lit_runs        = 0;
  int rep_runs        = 0;
  int max_burst       = 0;
  int gap_left        = 0;
  int stall_left      = 0;
  int in_mode         = 1;
  int out_mode        = 1;

  // idle length for one transfer: none, uniform, or occasional long pauses
  function automatic int pick_wait(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 14);
      default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
    endcase
  endfunction

  task automatic take_symbol(input logic [5:0] sym);
    case (phase)
      PH_LITERAL: begin
        lit_store[fill_cnt[4:0]] = sym;
        fill_cnt = fill_cnt + 6'd1;
        if (fill_cnt >= run_len) begin
          for (int i = 0; i < int'(run_len); i++) burst_syms = {burst_syms, lit_store[i]};
          lit_runs++;
          phase    = PH_HEADER;
          run_len  = '0;
          fill_cnt = '0;
        end
      end
      PH_REPEAT: begin
        for (int i = 0; i < int'(run_len); i++) burst_syms = {burst_syms, sym};
        rep_runs++;
        phase   = PH_HEADER;
        run_len = '0;
      end
      default: begin
        // negative header repeats the next symbol 1-h times
        if (sym[5]) begin
          run_len = 6'(7'd65 - {1'b0, sym});
          phase   = PH_REPEAT;
        end else begin
          run_len  = sym + 6'd1;
          fill_cnt = '0;
          phase    = PH_LITERAL;
        end
      end
    endcase
  endtask

  // works out every symbol that one accepted byte releases
  task automatic decode_byte(input in_t item);
    logic [12:0] acc;
    int          nbits;
    out_t        res;
    acc   = {left_bits, item.in_byte};
    nbits = int'(left_cnt) + 8;
    burst_syms.delete();
    while (nbits >= 6) begin
      nbits -= 6;
      take_symbol(6'((acc >> nbits) & 13'h3F));
    end
    left_bits = 5'(acc & ((13'd1 << nbits) - 13'd1));
    left_cnt  = 3'(nbits);
    // end of stream drops unfinished runs and trailing bits
    if (item.last_byte) begin
      left_bits = '0;
      left_cnt  = '0;
      phase     = PH_HEADER;
      run_len   = '0;
      fill_cnt  = '0;
    end
    foreach (burst_syms[i]) begin
      res.out_symbol = burst_syms[i];
      res.item_last  = (i == burst_syms.size() - 1);
      symbols_due = {symbols_due, res};
    end
    if (burst_syms.size() > max_burst) max_burst = burst_syms.size();
  endtask

  // packs sym_buf msb first into bytes, random pad bits, last byte flagged
  task automatic pack_syms();
    logic [15:0] acc;
    int          nbits;
    int          pad;
    in_t         item;
    in_t         held;
    bit          have;
    acc   = '0;
    nbits = 0;
    have  = 1'b0;
    foreach (sym_buf[i]) begin
      acc = {acc[9:0], sym_buf[i]};
      nbits += 6;
      if (nbits >= 8) begin
        nbits -= 8;
        item.in_byte   = 8'(acc >> nbits);
        item.last_byte = 1'b0;
        if (have) byte_q = {byte_q, held};
        held = item;
        have = 1'b1;
        acc  = acc & ((16'd1 << nbits) - 16'd1);
      end
    end
    if (nbits > 0) begin
      pad            = 8 - nbits;
      item.in_byte   = 8'((acc << pad) | 16'($urandom_range(0, (1 << pad) - 1)));
      item.last_byte = 1'b0;
      if (have) byte_q = {byte_q, held};
      held = item;
    end
    held.last_byte = 1'b1;
    byte_q = {byte_q, held};
  endtask

  // one well-formed stream of runs, optionally cut short before its end
  task automatic add_stream(input int n_runs, input bit cut);
    int len;
    int k;
    sym_buf.delete();
    for (int r = 0; r < n_runs; r++) begin
      if ($urandom_range(0, 1) == 1) begin
        len = ($urandom_range(0, 11) == 0) ? 32 : $urandom_range(1, 8);
        sym_buf = {sym_buf, 6'(len - 1)};
        for (int i = 0; i < len; i++) sym_buf = {sym_buf, 6'($urandom_range(0, 63))};
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 33) : $urandom_range(2, 9);
        sym_buf = {sym_buf, 6'(65 - len)};
        sym_buf = {sym_buf, 6'($urandom_range(0, 63))};
      end
    end
    if (cut && sym_buf.size() > 1) begin
      k = $urandom_range(1, (sym_buf.size() - 1 < 4) ? sym_buf.size() - 1 : 4);
      repeat (k) void'(sym_buf.pop_back());
    end
    pack_syms();
  endtask

  // driver: one item on the input port at a time, gaps drawn per transfer
  always @(negedge clk) begin : drive_bytes
    logic next_valid;
    in_t  next_data;
    next_valid = in_valid;
    next_data  = in_data;
    if (rst_n) begin
      if (in_valid && bytes_taken == n_issued) next_valid = 1'b0;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_q.size() > 0) begin
          next_data  = byte_q.pop_front();
          next_valid = 1'b1;
          n_issued++;
          if ($urandom_range(0, 39) == 0) in_mode = $urandom_range(0, 2);
          gap_left = pick_wait(in_mode);
        end
      end
    end
    in_valid <= next_valid;
    in_data  <= next_data;
  end

  // result side backpressure, a fresh stall length after every transfer
  always @(negedge clk) begin : drive_stall
    if (rst_n) begin
      if (results_seen != results_checked) begin
        results_seen = results_checked;
        if ($urandom_range(0, 39) == 0) out_mode = $urandom_range(0, 2);
        stall_left = pick_wait(out_mode);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: check results against the oldest expectation, predict accepted bytes
  always @(posedge clk) begin : watch
    out_t want;
    cycle_count++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (symbols_due.size() == 0) begin
          if (err_count < MAX_SHOWN)
            $display("unexpected result: sym %h last %b", out_data.out_symbol,
                     out_data.item_last);
          err_count++;
        end else begin
          want = symbols_due.pop_front();
          if (want.out_symbol !== out_data.out_symbol ||
              want.item_last !== out_data.item_last) begin
            if (err_count < MAX_SHOWN)
              $display("mismatch at result %0d: expected sym %h last %b, got sym %h last %b",
                       results_checked, want.out_symbol, want.item_last,
                       out_data.out_symbol, out_data.item_last);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_byte(in_data);
        bytes_taken++;
      end
    end
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout: %0d of %0d bytes taken, %0d results outstanding",
               bytes_taken, total_bytes, symbols_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    in_t item;
    int  n;

    // directed: shortest literal run, both repeat extremes, dropped runs
    sym_buf = '{6'd0, 6'h15};
    pack_syms();
    sym_buf = '{6'h3F, 6'h2A};
    pack_syms();
    sym_buf = '{6'h20, 6'h3F};
    pack_syms();
    sym_buf = '{6'h3F};
    pack_syms();
    sym_buf = '{6'd3, 6'h01, 6'h02};
    pack_syms();
    sym_buf = '{6'd1, 6'h3E, 6'h01, 6'h3C, 6'h05, 6'd0, 6'h00};
    pack_syms();
    // byte extremes, with and without end of stream
    item.in_byte = 8'h00; item.last_byte = 1'b0; byte_q = {byte_q, item};
    item.in_byte = 8'hFF; item.last_byte = 1'b1; byte_q = {byte_q, item};
    item.in_byte = 8'hFF; item.last_byte = 1'b0; byte_q = {byte_q, item};
    item.in_byte = 8'h00; item.last_byte = 1'b1; byte_q = {byte_q, item};
    directed_bytes = byte_q.size();

    // random: mostly well-formed streams, some cut short, some raw noise
    while (byte_q.size() - directed_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
          item.in_byte   = 8'($urandom_range(0, 255));
          item.last_byte = (k == n - 1) ? 1'b1 : 1'($urandom_range(0, 3) == 0);
          byte_q = {byte_q, item};
        end
      end else begin
        add_stream($urandom_range(1, 4), $urandom_range(0, 9) == 0);
      end
    end
    total_bytes = byte_q.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < total_bytes) @(posedge clk);
    while (symbols_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d compressed bytes (%0d directed), %0d symbols checked",
             total_bytes, directed_bytes, results_checked);
    $display("completed %0d literal and %0d repeat runs, longest burst from one byte %0d",
             lit_runs, rep_runs, max_burst);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
